// ===== design/sbps_pkg.sv =====
`default_nettype none
package sbps_pkg;
  localparam int DefMaxTerms = 64;
  localparam int DefExpBits  = 4;
  localparam int CoefW  = 32;
  localparam int ExpW   = 4;
  localparam int CoordW = 16;
  localparam int ValW   = 48;
  localparam int CountW = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  // Result of one Q3.12 multiply step.
  typedef struct packed {
    logic signed [ValW-1:0] t;
    logic                   sat;
  } mul_res_t;
endpackage
`default_nettype wire

// ===== design/sbps_if.sv =====
`default_nettype none
interface sbps_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [sbps_pkg::CoefW-1:0]  coef;
  logic [sbps_pkg::ExpW-1:0]          exp_x;
  logic [sbps_pkg::ExpW-1:0]          exp_y;
  logic signed [sbps_pkg::CoordW-1:0] x_value;
  logic signed [sbps_pkg::CoordW-1:0] y_value;
  modport source (output valid, op, coef, exp_x, exp_y, x_value, y_value, input ready);
  modport sink   (input valid, op, coef, exp_x, exp_y, x_value, y_value, output ready);
endinterface

interface sbps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sbps_pkg::ValW-1:0]   value;
  logic [sbps_pkg::CountW-1:0]        term_count;
  logic                               table_full;
  logic                               saturated;
  modport source (output valid, value, term_count, table_full, saturated, input ready);
  modport sink   (input valid, value, term_count, table_full, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/sbps_mem.sv =====
`default_nettype none
module sbps_mem #(
  parameter int Depth = 64,
  parameter int Width = 40
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/sbps_mul.sv =====
`default_nettype none
module sbps_mul (
  input  wire                                  clk,
  input  wire signed [sbps_pkg::ValW-1:0]      t,
  input  wire signed [sbps_pkg::CoordW-1:0]    v,
  output sbps_pkg::mul_res_t                   res
);
  import sbps_pkg::*;
  // 48 x 16 product is split into two halves, each below 32 x 32.
  logic signed [ValW+CoordW-1:0] prod_lo, prod_hi;
  logic signed [ValW+CoordW:0]   sum;
  logic signed [ValW+CoordW-12:0] q;

  // Stage one: partial products registered.
  always_ff @(posedge clk) begin
    prod_lo <= $signed({1'b0, t[23:0]}) * v;
    prod_hi <= (ValW+CoordW)'($signed(t[ValW-1:24]) * v) <<< 24;
  end

  // Stage two: round half up, shift, saturate (registered in caller).
  always_comb begin
    sum = (ValW+CoordW+1)'(prod_lo) + (ValW+CoordW+1)'(prod_hi) + 2048;
    q   = sum[ValW+CoordW:12];
    res.sat = 1'b0;
    res.t   = q[ValW-1:0];
    if (q > $signed((ValW+CoordW-11)'(ValMax))) begin
      res.t = ValMax; res.sat = 1'b1;
    end else if (q < $signed((ValW+CoordW-11)'(ValMin))) begin
      res.t = ValMin; res.sat = 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/sparse_bivariate_poly_store.sv =====
`default_nettype none
// Channel | Dir | Carries
// in_ch   | in  | op, coef, exp_x, exp_y, x_value, y_value
// out_ch  | out | value, term_count, table_full, saturated
// An insert searches the table entry by entry (read, then compare). With no
// match it appends the term, or sets table_full if there is no room. When a term is
// removed, each later entry is read and then written one slot down.
// An evaluate reads each term, steps it through the shared multiplier once
// per exponent unit, then adds it to the accumulator.
// Reset clears the count, the output valid flag and the sequencer state; the term memory needs no clearing.
// A finished request waits in the output register. The next request may be
// taken meanwhile, and its result holds in the sequencer until the register is free.
module sparse_bivariate_poly_store #(
  parameter int MAX_TERMS = sbps_pkg::DefMaxTerms,
  parameter int EXP_BITS  = sbps_pkg::DefExpBits
) (
  input wire clk,
  input wire rst,
  sbps_in_if.sink    in_ch,
  sbps_out_if.source out_ch
);
  import sbps_pkg::*;
  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int EW = CoefW + 2 * EXP_BITS;

  localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCHK = 4'd2,
    S_SHRD = 4'd3, S_SHWR = 4'd4, S_ERD = 4'd5, S_ELD = 4'd6,
    S_EMUL = 4'd7, S_EMW = 4'd8, S_EMR = 4'd9, S_DONE = 4'd10;

  logic [3:0] state;
  logic [CW-1:0] count, idx;
  logic in_op;
  logic signed [CoefW-1:0] in_coef;
  logic [EXP_BITS-1:0] in_ex, in_ey, ex_left, ey_left;
  logic signed [CoordW-1:0] in_x, in_y;
  logic signed [ValW-1:0] acc, term;
  logic sat, full;
  logic ovalid;
  logic signed [ValW-1:0] ovalue;
  logic [CountW-1:0] ocount;
  logic ofull, osat;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic signed [CoefW-1:0] r_coef;
  logic [EXP_BITS-1:0] r_ex, r_ey;
  logic signed [CoefW:0] csum;
  logic signed [ValW:0] asum;
  logic signed [CoordW-1:0] mul_v;
  mul_res_t mres;

  assign r_coef = rdata[EW-1 -: CoefW];
  assign r_ex   = rdata[2*EXP_BITS-1:EXP_BITS];
  assign r_ey   = rdata[EXP_BITS-1:0];
  assign csum   = (CoefW+1)'(r_coef) + (CoefW+1)'(in_coef);
  assign asum   = (ValW+1)'(acc) + (ValW+1)'(term);
  assign mul_v  = (ex_left != '0) ? in_x : in_y;

  sbps_mem #(.Depth(MAX_TERMS), .Width(EW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  sbps_mul u_mul (.clk(clk), .t(term), .v(mul_v), .res(mres));

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = ovalid;
  assign out_ch.value     = ovalue;
  assign out_ch.term_count = ocount;
  assign out_ch.table_full = ofull;
  assign out_ch.saturated  = osat;

  // Memory port control.
  always_comb begin
    we = 1'b0; waddr = idx[AW-1:0]; wdata = {in_coef, in_ex, in_ey};
    raddr = idx[AW-1:0];
    case (state)
      S_SCHK: begin
        if (idx < count && r_ex == in_ex && r_ey == in_ey) begin
          if (csum[CoefW:CoefW-1] == 2'b01) wdata = {{1'b0, {(CoefW-1){1'b1}}}, in_ex, in_ey};
          else if (csum[CoefW:CoefW-1] == 2'b10) wdata = {{1'b1, {(CoefW-1){1'b0}}}, in_ex, in_ey};
          else wdata = {csum[CoefW-1:0], in_ex, in_ey};
          we = (csum != '0);
        end else if (idx >= count && count < CW'(MAX_TERMS)) begin
          we = 1'b1;
        end
      end
      S_SHWR: begin
        we = 1'b1; waddr = AW'(idx - 1'b1); wdata = rdata;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; ovalid <= 1'b0; idx <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            in_op <= in_ch.op; in_coef <= in_ch.coef;
            in_ex <= EXP_BITS'(in_ch.exp_x); in_ey <= EXP_BITS'(in_ch.exp_y);
            in_x <= in_ch.x_value; in_y <= in_ch.y_value;
            idx <= '0; acc <= '0; sat <= 1'b0; full <= 1'b0;
            state <= (in_ch.op == OP_EVAL) ? S_ERD : S_SRD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (idx < count && r_ex == in_ex && r_ey == in_ey) begin
            sat <= (csum[CoefW] != csum[CoefW-1]);
            if (csum == '0) begin
              idx <= idx + 1'b1; state <= S_SHRD;
            end else state <= S_DONE;
          end else if (idx >= count) begin
            if (count < CW'(MAX_TERMS)) count <= count + 1'b1;
            else full <= 1'b1;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1; state <= S_SRD;
          end
        end
        S_SHRD: begin
          if (idx < count) state <= S_SHWR;
          else begin
            count <= count - 1'b1; state <= S_DONE;
          end
        end
        S_SHWR: begin
          idx <= idx + 1'b1; state <= S_SHRD;
        end
        S_ERD: state <= (idx < count) ? S_ELD : S_DONE;
        S_ELD: begin
          term <= ValW'(r_coef); ex_left <= r_ex; ey_left <= r_ey;
          state <= S_EMUL;
        end
        S_EMUL: begin
          if (ex_left == '0 && ey_left == '0) begin
            if (asum[ValW] != asum[ValW-1]) begin
              acc <= asum[ValW] ? ValMin : ValMax; sat <= 1'b1;
            end else acc <= asum[ValW-1:0];
            idx <= idx + 1'b1; state <= S_ERD;
          end else state <= S_EMW;
        end
        S_EMW: state <= S_EMR;
        S_EMR: begin
          term <= mres.t;
          if (mres.sat) sat <= 1'b1;
          if (ex_left != '0) ex_left <= ex_left - 1'b1;
          else ey_left <= ey_left - 1'b1;
          state <= S_EMUL;
        end
        S_DONE: begin
          // Load the output register once it is empty or being emptied.
          if (!ovalid || out_ch.ready) begin
            ovalid <= 1'b1;
            ovalue <= (in_op == OP_EVAL) ? acc : '0;
            ocount <= CountW'(count);
            ofull <= full; osat <= sat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The term count never exceeds the table depth.
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_TERMS))
    else $error("term count beyond depth");
  // A dropped term leaves the count at full depth.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && full) |-> (count == CW'(MAX_TERMS))) else $error("full flag with room");
  // A stalled result stays valid and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out_ch.ready) |=> (ovalid && $stable(ovalue) && $stable(ocount)))
    else $error("stalled result changed");
endmodule
`default_nettype wire
